@@ rtl/rbgc_pkg.sv @@
// Shared constants, types and helpers for the rigid body ground contact block.
package rbgc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DIV_W      = 33 + FRAC_BITS;   // dividend width: drop magnitude << FRAC_BITS
  localparam int SQRT_STEPS = 32;               // result bits of the 64-bit square root
  localparam int CNT_W      = $clog2(DIV_W);
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPIN_LIMIT  = 2'd1;
  localparam logic [1:0] REG_LIFTOFF     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ITER,
    ST_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] sq_sel;
    logic       iter_step;
    logic       sqrt_en;
    logic       commit;
  } cmd_t;

  // clamp a signed value to +/- an unsigned limit
  function automatic logic [31:0] clamp_abs(input logic [31:0] v, input logic [30:0] lim);
    logic signed [32:0] vs;
    logic signed [32:0] ls;
    logic signed [32:0] r;
    vs = {v[31], v};
    ls = {2'b00, lim};
    if (vs > ls) begin
      r = ls;
    end else if (vs < -ls) begin
      r = -ls;
    end else begin
      r = vs;
    end
    return r[31:0];
  endfunction

endpackage

@@ rtl/rigid_body_ground_contact.sv @@
// Rigid body ground contact: top level joining controller and datapath.
// An accepted item steps through the square, divide/root and commit states in that order.
// A new item is taken only after the previous one commits; the pace is set by the
// bit-serial restoring divider (33 + FRAC_BITS quotient bits); the 32-step root runs alongside it.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset restores register defaults, clears contact flag, clearance and peak.
module rigid_body_ground_contact
  import rbgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] height,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] spin_x,
  input  logic [31:0] spin_y,
  input  logic [31:0] spin_z,
  input  logic [31:0] ground_level,
  input  logic [30:0] thrust,
  input  logic [30:0] step_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] new_height,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_vel_z,
  output logic [31:0] out_spin_x,
  output logic [31:0] out_spin_y,
  output logic [31:0] out_spin_z,
  output logic        touching,
  output logic [30:0] peak_impact
);

  cmd_t cmd;

  rbgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rbgc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_index    (cfg_index),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .height       (height),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .spin_x       (spin_x),
    .spin_y       (spin_y),
    .spin_z       (spin_z),
    .ground_level (ground_level),
    .thrust       (thrust),
    .step_time    (step_time),
    .new_height   (new_height),
    .out_vel_x    (out_vel_x),
    .out_vel_y    (out_vel_y),
    .out_vel_z    (out_vel_z),
    .out_spin_x   (out_spin_x),
    .out_spin_y   (out_spin_y),
    .out_spin_z   (out_spin_z),
    .touching     (touching),
    .peak_impact  (peak_impact)
  );

endmodule

@@ rtl/rbgc_ctrl.sv @@
// Sequencer for the contact datapath: load, squares, divide/root iterations, commit.
module rbgc_ctrl
  import rbgc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // state, counter and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.sq_sel    = cnt[1:0];
    cmd.sqrt_en   = (cnt < CNT_W'(SQRT_STEPS));
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (cnt == CNT_W'(3)) begin
          cnt_next   = '0;
          state_next = ST_ITER;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ITER: begin
        cmd.iter_step = 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          cnt_next   = '0;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // commit never overwrites an untaken result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over pending result");
  // an accepted beat starts the square phase
  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SQUARE))
    else $error("load did not start squares");
  // a commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit without result");

endmodule

@@ rtl/rbgc_dp.sv @@
// Contact datapath: clamps, squares, restoring divider, bit-serial root, state and results.
module rbgc_dp
  import rbgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  input  logic [31:0] height,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic [31:0] spin_x,
  input  logic [31:0] spin_y,
  input  logic [31:0] spin_z,
  input  logic [31:0] ground_level,
  input  logic [30:0] thrust,
  input  logic [30:0] step_time,
  output logic [31:0] new_height,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_vel_z,
  output logic [31:0] out_spin_x,
  output logic [31:0] out_spin_y,
  output logic [31:0] out_spin_z,
  output logic        touching,
  output logic [30:0] peak_impact
);

  logic [30:0] speed_limit;
  logic [30:0] spin_limit;
  logic [30:0] liftoff_thrust;
  logic        contact_flag;
  logic [31:0] last_clearance;
  logic [30:0] impact_peak;

  logic [31:0] h_r, g_r, vx, vy, vz, wx, wy, wz;
  logic [30:0] thr_r, dt_r;
  logic        drop_pos;

  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] quo;
  logic [30:0]      drem;
  logic [63:0]      acc;
  logic [61:0]      prod;
  logic [35:0]      srem;
  logic [31:0]      root;

  // load-time arithmetic
  logic signed [32:0] diff_in;
  logic signed [34:0] drop;
  assign diff_in = $signed({height[31], height}) - $signed({ground_level[31], ground_level});
  assign drop    = $signed({{3{last_clearance[31]}}, last_clearance})
                 - $signed({{2{diff_in[32]}}, diff_in});

  // squares operand
  logic [31:0] sq_v;
  logic [30:0] sq_abs;
  always_comb begin
    case (cmd.sq_sel)
      2'd0:    sq_v = vx;
      2'd1:    sq_v = vy;
      2'd2:    sq_v = vz;
      default: sq_v = '0;
    endcase
  end
  assign sq_abs = sq_v[31] ? 31'(-sq_v) : sq_v[30:0];

  // divider and root step
  logic [31:0] d_sh;
  logic        d_ge;
  logic [35:0] s_sh;
  logic [35:0] s_trial;
  logic        s_ge;
  assign d_sh    = {drem, dvd[DIV_W-1]};
  assign d_ge    = d_sh >= {1'b0, dt_r};
  assign s_sh    = {srem[33:0], acc[63:62]};
  assign s_trial = {2'b00, root, 2'b01};
  assign s_ge    = s_sh >= s_trial;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit    <= 31'd13107200;
      spin_limit     <= 31'd655360;
      liftoff_thrust <= MAX31;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_LIMIT: speed_limit    <= cfg_data;
        REG_SPIN_LIMIT:  spin_limit     <= cfg_data;
        REG_LIFTOFF:     liftoff_thrust <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      h_r      <= height;
      g_r      <= ground_level;
      vx       <= clamp_abs(vel_x, speed_limit);
      vy       <= clamp_abs(vel_y, speed_limit);
      vz       <= clamp_abs(vel_z, speed_limit);
      wx       <= clamp_abs(spin_x, spin_limit);
      wy       <= clamp_abs(spin_y, spin_limit);
      wz       <= clamp_abs(spin_z, spin_limit);
      thr_r    <= thrust;
      dt_r     <= step_time;
      drop_pos <= !drop[34] && (drop != '0);
      dvd      <= {drop[32:0], {FRAC_BITS{1'b0}}};
      quo      <= '0;
      drem     <= '0;
      acc      <= '0;
      prod     <= '0;
      srem     <= '0;
      root     <= '0;
    end else if (cmd.sq_step) begin
      prod <= sq_abs * sq_abs;
      acc  <= acc + {2'b00, prod};
    end else if (cmd.iter_step) begin
      dvd  <= {dvd[DIV_W-2:0], 1'b0};
      quo  <= {quo[DIV_W-2:0], d_ge};
      drem <= d_ge ? 31'(d_sh - {1'b0, dt_r}) : d_sh[30:0];
      if (cmd.sqrt_en) begin
        acc  <= {acc[61:0], 2'b00};
        srem <= s_ge ? (s_sh - s_trial) : s_sh;
        root <= {root[30:0], s_ge};
      end
    end
  end

  // commit-time results
  logic signed [32:0] diff;
  logic               below;
  logic               on_ground;
  logic               stuck;
  logic [30:0]        q_sat;
  logic [31:0]        c_min;
  logic [30:0]        closing;
  assign diff      = $signed({h_r[31], h_r}) - $signed({g_r[31], g_r});
  assign below     = $signed(h_r) < $signed(g_r);
  assign on_ground = below || (h_r == g_r);
  assign stuck     = on_ground && (thr_r <= liftoff_thrust);
  assign q_sat     = (quo > DIV_W'(MAX31)) ? MAX31 : quo[30:0];
  assign c_min     = ({1'b0, q_sat} < root) ? {1'b0, q_sat} : root;
  assign closing   = (drop_pos && dt_r != '0) ? c_min[30:0] : '0;

  // step state
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_flag   <= 1'b0;
      last_clearance <= '0;
      impact_peak    <= '0;
    end else if (cmd.commit) begin
      contact_flag <= on_ground;
      if (below) begin
        last_clearance <= '0;
      end else if (diff > 33'sh0_7FFF_FFFF) begin
        last_clearance <= 32'h7FFF_FFFF;
      end else begin
        last_clearance <= diff[31:0];
      end
      if (below && !contact_flag && closing > impact_peak) begin
        impact_peak <= closing;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      new_height <= below ? g_r : h_r;
      out_vel_x  <= stuck ? '0 : vx;
      out_vel_y  <= (stuck || (below && vy[31])) ? '0 : vy;
      out_vel_z  <= stuck ? '0 : vz;
      out_spin_x <= stuck ? '0 : wx;
      out_spin_y <= stuck ? '0 : wy;
      out_spin_z <= stuck ? '0 : wz;
      touching   <= on_ground;
      peak_impact <= (below && !contact_flag && closing > impact_peak) ? closing : impact_peak;
    end
  end

  // peak never falls
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (impact_peak >= $past(impact_peak)))
    else $error("impact peak decreased");
  // grounded commit sets contact flag
  a_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && on_ground) |=> contact_flag)
    else $error("contact flag not set");
  // snapped height never lies below ground
  a_snap: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> ($signed(new_height) >= $signed($past(g_r))))
    else $error("height below ground after snap");

endmodule
